// ===== rtl/lzf_pkg.sv =====
// ---------------------------------------------------------------------------
// lzf_pkg
// Shared types and constants of the LZF stream decompressor.
// ---------------------------------------------------------------------------
`default_nettype none

package lzf_pkg;

  // History window and chunk geometry
  localparam int WINDOW_BYTES = 8192;
  localparam int LANES        = 8;
  localparam int OUT_LANES    = 8;
  localparam int CHUNK_BYTES  = (LANES < OUT_LANES) ? LANES : OUT_LANES;
  localparam int HIST_AW      = $clog2(WINDOW_BYTES);

  // Field widths fixed by the stream format
  localparam int SIZE_W  = 32;
  localparam int LEN_W   = 9;
  localparam int OFS_W   = 14;
  localparam int COUNT_W = 4;
  localparam int LIT_W   = 6;

  // Command queue between parser and copy engine
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Stream control byte decoding
  localparam logic [7:0] LIT_LIMIT = 8'h20;
  localparam logic [2:0] LEN_EXT   = 3'd7;
  localparam logic [LEN_W-1:0] LEN_BIAS     = 9'd2;
  localparam logic [LEN_W-1:0] LEN_EXT_BIAS = 9'd9;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_OFFSET = 2'd1,
    ERR_TRUNC  = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    CMD_LIT   = 2'd0,
    CMD_MATCH = 2'd1,
    CMD_ERR   = 2'd2
  } cmd_kind_t;

  // One classified command, with the output count at which it starts
  typedef struct packed {
    cmd_kind_t         kind;
    byte_t             lit_byte;
    logic [OFS_W-1:0]  offset;
    logic [LEN_W-1:0]  len;
    logic              trunc;
    logic [SIZE_W-1:0] base;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lzf_in_if.sv =====
// ---------------------------------------------------------------------------
// lzf_in_if
// Compressed byte channel: valid/ready handshake with byte and stream start.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_stream;

  modport source (output valid, data_byte, start_of_stream, input ready);
  modport sink   (input valid, data_byte, start_of_stream, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzf_out_if.sv =====
// ---------------------------------------------------------------------------
// lzf_out_if
// Decompressed chunk channel: valid/ready handshake with up to eight bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte_0;
  logic [7:0] out_byte_1;
  logic [7:0] out_byte_2;
  logic [7:0] out_byte_3;
  logic [7:0] out_byte_4;
  logic [7:0] out_byte_5;
  logic [7:0] out_byte_6;
  logic [7:0] out_byte_7;
  logic [3:0] byte_count;
  logic       run_last;
  logic       stream_done;
  logic [1:0] error_code;

  modport source (
    output valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_byte_4,
           out_byte_5, out_byte_6, out_byte_7, byte_count, run_last,
           stream_done, error_code,
    input  ready
  );
  modport sink (
    input  valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_byte_4,
           out_byte_5, out_byte_6, out_byte_7, byte_count, run_last,
           stream_done, error_code,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lzf_front.sv =====
// ---------------------------------------------------------------------------
// lzf_front
// Stream parser: takes one compressed byte per cycle if the queue has room,
// tracks output count, turns literals and back references into copy commands.
// ---------------------------------------------------------------------------
`default_nettype none

module lzf_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [lzf_pkg::SIZE_W-1:0] output_size,
  lzf_in_if.sink                         in_chan,
  input  wire logic                      cmdq_full,
  output      logic                      push_v,
  output      lzf_pkg::cmd_t             push_cmd
);
  import lzf_pkg::*;

  typedef enum logic [3:0] {
    PH_CTRL  = 4'b0001,
    PH_LIT   = 4'b0010,
    PH_EXTRA = 4'b0100,
    PH_OFFS  = 4'b1000
  } phase_t;

  phase_t            ph_r, ph_nxt, ph_eff;
  logic [LIT_W-1:0]  lit_r, lit_nxt, lit_eff, lit_dec;
  logic [LEN_W-1:0]  mlen_r, mlen_nxt, mlen_eff;
  logic [4:0]        offhi_r, offhi_nxt, offhi_eff;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic [SIZE_W-1:0] room;
  logic [OFS_W-1:0]  offset;
  logic              accept;
  logic              trunc;
  byte_t             data;

  // Take a byte whenever the command queue has room
  assign in_chan.ready = !cmdq_full;
  assign accept        = in_chan.valid && !cmdq_full;
  assign data          = in_chan.data_byte;

  always_comb begin
    // Apply stream start before the byte is parsed
    ph_eff    = ph_r;
    lit_eff   = lit_r;
    mlen_eff  = mlen_r;
    offhi_eff = offhi_r;
    cnt_eff   = cnt_r;
    if (in_chan.start_of_stream) begin
      ph_eff    = PH_CTRL;
      lit_eff   = '0;
      mlen_eff  = '0;
      offhi_eff = '0;
      cnt_eff   = '0;
    end

    offset  = {1'b0, offhi_eff, data} + OFS_W'(1);
    room    = output_size - cnt_eff;
    trunc   = SIZE_W'(mlen_eff) > room;
    lit_dec = (lit_eff != '0) ? (lit_eff - LIT_W'(1)) : '0;

    ph_nxt    = ph_r;
    lit_nxt   = lit_r;
    mlen_nxt  = mlen_r;
    offhi_nxt = offhi_r;
    cnt_nxt   = cnt_r;
    push_v    = 1'b0;
    push_cmd  = '0;
    push_cmd.base = cnt_eff;

    if (accept) begin
      ph_nxt    = ph_eff;
      lit_nxt   = lit_eff;
      mlen_nxt  = mlen_eff;
      offhi_nxt = offhi_eff;
      cnt_nxt   = cnt_eff;
      // Drop bytes once the stream is complete
      if (cnt_eff < output_size) begin
        case (ph_eff)
          PH_CTRL: begin
            if (data < LIT_LIMIT) begin
              lit_nxt = LIT_W'(data[4:0]) + LIT_W'(1);
              ph_nxt  = PH_LIT;
            end else begin
              offhi_nxt = data[4:0];
              if (data[7:5] == LEN_EXT) begin
                ph_nxt = PH_EXTRA;
              end else begin
                mlen_nxt = LEN_W'(data[7:5]) + LEN_BIAS;
                ph_nxt   = PH_OFFS;
              end
            end
          end
          PH_LIT: begin
            push_v            = 1'b1;
            push_cmd.kind     = CMD_LIT;
            push_cmd.lit_byte = data;
            cnt_nxt           = cnt_eff + SIZE_W'(1);
            lit_nxt           = lit_dec;
            if (lit_dec == '0) begin
              ph_nxt = PH_CTRL;
            end
          end
          PH_EXTRA: begin
            mlen_nxt = LEN_W'(data) + LEN_EXT_BIAS;
            ph_nxt   = PH_OFFS;
          end
          PH_OFFS: begin
            ph_nxt = PH_CTRL;
            push_v = 1'b1;
            if (SIZE_W'(offset) > cnt_eff) begin
              push_cmd.kind = CMD_ERR;
            end else begin
              push_cmd.kind   = CMD_MATCH;
              push_cmd.offset = offset;
              push_cmd.trunc  = trunc;
              push_cmd.len    = trunc ? room[LEN_W-1:0] : mlen_eff;
              cnt_nxt         = trunc ? output_size : (cnt_eff + SIZE_W'(mlen_eff));
            end
          end
          default: begin
            ph_nxt = PH_CTRL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_CTRL;
      lit_r   <= '0;
      mlen_r  <= '0;
      offhi_r <= '0;
      cnt_r   <= '0;
    end else begin
      ph_r    <= ph_nxt;
      lit_r   <= lit_nxt;
      mlen_r  <= mlen_nxt;
      offhi_r <= offhi_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lzf_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// lzf_cmd_fifo
// Short command queue between the parser and the copy engine.
// ---------------------------------------------------------------------------
`default_nettype none

module lzf_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_v,
  input  wire lzf_pkg::cmd_t push_cmd,
  output      logic          full,
  output      logic          head_v,
  output      lzf_pkg::cmd_t head_cmd,
  input  wire logic          pop
);
  import lzf_pkg::*;

  cmd_t               entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, rp_r;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign head_v   = (cnt_r != '0);
  assign head_cmd = entry_r[rp_r];
  assign do_push  = push_v && !full;
  assign do_pop   = pop && head_v;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (CMDQ_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (CMDQ_AW+1)'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + CMDQ_AW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lzf_back.sv =====
// ---------------------------------------------------------------------------
// lzf_back
// Copy engine: writes the history window, copies matches one byte a cycle
// through a registered read port unless the output stalls, packs bytes into
// chunks and holds the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lzf_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [lzf_pkg::SIZE_W-1:0] output_size,
  input  wire logic                       cmd_v,
  input  wire lzf_pkg::cmd_t              cmd,
  output      logic                       cmd_pop,
  lzf_out_if.source                       out_chan
);
  import lzf_pkg::*;

  localparam logic [COUNT_W-1:0] CHUNK_FILL = COUNT_W'(CHUNK_BYTES);

  // History memory and read port
  byte_t              hist_mem [WINDOW_BYTES];
  byte_t              rd_q, fwd_data_r, rd_byte;
  logic               fwd_hit_r;
  logic [HIST_AW-1:0] wa;

  // Copy control
  logic               act_r, act_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [HIST_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic               trunc_r, trunc_nxt;
  logic               pend_v_r, pend_last_r;
  logic [SIZE_W-1:0]  wr_cnt_r, wr_cnt_nxt, wr_base;
  logic               issue;

  // Chunk assembly
  byte_t              chunk_r [OUT_LANES];
  byte_t              chunk_nxt [OUT_LANES];
  byte_t              chunk_cmp [OUT_LANES];
  logic [COUNT_W-1:0] fill_r, fill_nxt, new_fill, cmp_fill;
  logic               done_r, done_nxt;
  logic               ck_last_r, ck_last_nxt;
  err_code_t          ck_err_r, ck_err_nxt;

  // Output register
  byte_t              ob_r [OUT_LANES];
  logic               out_v_r, out_v_nxt;
  logic [COUNT_W-1:0] ocnt_r;
  logic               olast_r, odone_r;
  err_code_t          oerr_r;

  logic      idle, lit_pop, err_pop, match_pop;
  logic      out_can_load, byte_ev, ev_last, complete_ev, ready_chunk, load;
  byte_t     ev_byte;
  err_code_t ev_err;
  logic      src_last;
  err_code_t src_err;

  always_comb begin
    // Command decode: take a new command only when fully drained
    idle       = !act_r && !pend_v_r && !done_r;
    cmd_pop    = idle && cmd_v;
    lit_pop    = cmd_pop && (cmd.kind == CMD_LIT);
    err_pop    = cmd_pop && (cmd.kind == CMD_ERR);
    match_pop  = cmd_pop && (cmd.kind == CMD_MATCH);

    out_can_load = !out_v_r || out_chan.ready;
    rd_byte      = fwd_hit_r ? fwd_data_r : rd_q;

    // Byte arriving this cycle: copied byte or literal
    byte_ev  = pend_v_r || lit_pop;
    ev_byte  = pend_v_r ? rd_byte : cmd.lit_byte;
    ev_last  = pend_v_r ? pend_last_r : 1'b1;
    ev_err   = (pend_v_r && pend_last_r && trunc_r) ? ERR_TRUNC : ERR_NONE;
    wr_base  = lit_pop ? cmd.base : wr_cnt_r;
    wa       = wr_base[HIST_AW-1:0];
    new_fill = fill_r + COUNT_W'(1);

    for (int k = 0; k < OUT_LANES; k++) begin
      chunk_cmp[k] = (byte_ev && (fill_r == COUNT_W'(k))) ? ev_byte : chunk_r[k];
    end
    cmp_fill    = byte_ev ? new_fill : fill_r;
    complete_ev = (byte_ev && ((new_fill == CHUNK_FILL) || ev_last)) || err_pop;
    ready_chunk = done_r || complete_ev;
    load        = ready_chunk && out_can_load;

    if (done_r) begin
      src_last = ck_last_r;
      src_err  = ck_err_r;
    end else if (err_pop) begin
      src_last = 1'b1;
      src_err  = ERR_OFFSET;
    end else begin
      src_last = ev_last;
      src_err  = ev_err;
    end

    // Chunk buffer: clear on hand-off, else hold what was gathered
    if (load) begin
      for (int k = 0; k < OUT_LANES; k++) begin
        chunk_nxt[k] = '0;
      end
      fill_nxt = '0;
      done_nxt = 1'b0;
    end else begin
      chunk_nxt = chunk_cmp;
      fill_nxt  = cmp_fill;
      done_nxt  = ready_chunk;
    end
    ck_last_nxt = src_last;
    ck_err_nxt  = src_err;

    out_v_nxt = load ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);

    // Output count and history write address
    wr_cnt_nxt = wr_cnt_r;
    if (byte_ev) begin
      wr_cnt_nxt = wr_base + SIZE_W'(1);
    end else if (match_pop || err_pop) begin
      wr_cnt_nxt = cmd.base;
    end

    // Issue a history read unless the byte could not be placed
    issue = act_r && !done_r &&
            !(pend_v_r && (new_fill == CHUNK_FILL) && !out_can_load);

    act_nxt    = act_r;
    rem_nxt    = rem_r;
    rd_ptr_nxt = rd_ptr_r;
    trunc_nxt  = trunc_r;
    if (match_pop) begin
      act_nxt    = 1'b1;
      rem_nxt    = cmd.len;
      rd_ptr_nxt = cmd.base[HIST_AW-1:0] - HIST_AW'(cmd.offset);
      trunc_nxt  = cmd.trunc;
    end else if (issue) begin
      rem_nxt    = rem_r - LEN_W'(1);
      rd_ptr_nxt = rd_ptr_r + HIST_AW'(1);
      act_nxt    = (rem_r != LEN_W'(1));
    end
  end

  // History memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (byte_ev) begin
      hist_mem[wa] <= ev_byte;
    end
    if (issue) begin
      rd_q <= hist_mem[rd_ptr_r];
    end
  end

  // Forward a byte written in the same cycle as its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (issue) begin
      fwd_hit_r <= byte_ev && (wa == rd_ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      fwd_data_r <= ev_byte;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      rem_r       <= '0;
      pend_v_r    <= 1'b0;
      pend_last_r <= 1'b0;
      wr_cnt_r    <= '0;
      fill_r      <= '0;
      done_r      <= 1'b0;
      out_v_r     <= 1'b0;
      for (int k = 0; k < OUT_LANES; k++) begin
        chunk_r[k] <= '0;
      end
    end else begin
      act_r       <= act_nxt;
      rem_r       <= rem_nxt;
      pend_v_r    <= issue;
      pend_last_r <= issue && (rem_r == LEN_W'(1));
      wr_cnt_r    <= wr_cnt_nxt;
      fill_r      <= fill_nxt;
      done_r      <= done_nxt;
      out_v_r     <= out_v_nxt;
      chunk_r     <= chunk_nxt;
    end
  end

  // Copy pointer and chunk flags
  always_ff @(posedge clk) begin
    rd_ptr_r  <= rd_ptr_nxt;
    trunc_r   <= trunc_nxt;
    ck_last_r <= ck_last_nxt;
    ck_err_r  <= ck_err_nxt;
  end

  // Output register load
  always_ff @(posedge clk) begin
    if (load) begin
      ob_r    <= chunk_cmp;
      ocnt_r  <= cmp_fill;
      olast_r <= src_last;
      oerr_r  <= src_err;
      odone_r <= (wr_cnt_nxt >= output_size);
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.out_byte_0  = ob_r[0];
  assign out_chan.out_byte_1  = ob_r[1];
  assign out_chan.out_byte_2  = ob_r[2];
  assign out_chan.out_byte_3  = ob_r[3];
  assign out_chan.out_byte_4  = ob_r[4];
  assign out_chan.out_byte_5  = ob_r[5];
  assign out_chan.out_byte_6  = ob_r[6];
  assign out_chan.out_byte_7  = ob_r[7];
  assign out_chan.byte_count  = ocnt_r;
  assign out_chan.run_last    = olast_r;
  assign out_chan.stream_done = odone_r;
  assign out_chan.error_code  = oerr_r;

endmodule

`default_nettype wire

// ===== rtl/lzf_stream_decompressor.sv =====
// ---------------------------------------------------------------------------
// lzf_stream_decompressor
// LZF stream decompressor with an 8 KiB history window.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one compressed byte per item; start_of_stream on an item
//   restarts the parser and the output count before that byte is parsed.
//   out_chan carries chunks of up to eight decompressed bytes, byte_count
//   valid; run_last marks the last chunk caused by one compressed byte.
//   cfg_we/cfg_wdata load the expected decompressed size, which the user
//   must load only while the block is idle; the block does not enforce it.
//   Bytes arriving after that many are output are dropped.
//   Throughput: the parser takes one item per cycle while its four-entry
//   command queue has room. The copy engine copies one match byte per cycle
//   through the single history read port while the output can take it, and
//   takes a new command only once the last is drained. A literal passes
//   through the command queue and the output register before out_chan.
//   Reset: synchronous, active low; clears the parser, queue, count and
//   output register. The history needs no clearing pass.
//   Receiver stall: the output register holds; the engine keeps gathering
//   the next chunk, then stops, the queue fills and in_chan.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module lzf_stream_decompressor (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [lzf_pkg::SIZE_W-1:0] cfg_wdata,
  lzf_in_if.sink                          in_chan,
  lzf_out_if.source                       out_chan
);
  import lzf_pkg::*;

  logic [SIZE_W-1:0] output_size_r;
  logic              cmdq_full, push_v, head_v, pop;
  cmd_t              push_cmd, head_cmd;

  // Hold the configured stream size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_size_r <= '0;
    end else if (cfg_we) begin
      output_size_r <= cfg_wdata;
    end
  end

  lzf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .output_size (output_size_r),
    .in_chan     (in_chan),
    .cmdq_full   (cmdq_full),
    .push_v      (push_v),
    .push_cmd    (push_cmd)
  );

  lzf_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_v   (push_v),
    .push_cmd (push_cmd),
    .full     (cmdq_full),
    .head_v   (head_v),
    .head_cmd (head_cmd),
    .pop      (pop)
  );

  lzf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .output_size (output_size_r),
    .cmd_v       (head_v),
    .cmd         (head_cmd),
    .cmd_pop     (pop),
    .out_chan    (out_chan)
  );

endmodule

`default_nettype wire

// ===== rtl/lzf_checker.sv =====
// ---------------------------------------------------------------------------
// lzf_checker
// Port-level checks on the decompressor's chunk channel.
// ---------------------------------------------------------------------------
`default_nettype none

module lzf_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  lzf_out_if.source out_chan
);
  import lzf_pkg::*;

  // A stalled item stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid)
    else $error("chunk withdrawn while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.byte_count <= COUNT_W'(OUT_LANES))
    else $error("chunk byte count too large");

  // Any error ends the run of chunks for that byte
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.error_code != ERR_NONE) |-> out_chan.run_last)
    else $error("error flagged on a chunk that is not last");

  a_offset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.error_code == ERR_OFFSET) |->
      out_chan.byte_count == '0)
    else $error("offset error chunk carries bytes");

  a_empty_is_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.byte_count == '0) |->
      out_chan.error_code == ERR_OFFSET)
    else $error("empty chunk without offset error");

endmodule

bind lzf_stream_decompressor lzf_checker u_lzf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_chan (out_chan)
);

`default_nettype wire

// ===== test/lzf_output_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzf_output_checker
// Watches the compressed byte channel, the size register and the chunk
// channel of the LZF decompressor. Decodes every accepted compressed byte
// with its own parser and history window, queues the chunks it predicts and
// compares each accepted chunk, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module lzf_output_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lzf_pkg::SIZE_W-1:0] cfg_wdata,
  lzf_in_if                          in_mon,
  lzf_out_if                         out_mon,
  output int                         mismatches,
  output int                         chunks_awaited
);
  import lzf_pkg::*;

  typedef enum logic [1:0] {
    EXPECT_CONTROL,
    EXPECT_LITERAL,
    EXPECT_LENGTH,
    EXPECT_OFFSET
  } parse_stage_t;

  typedef struct packed {
    byte_t [OUT_LANES-1:0] lanes;
    logic [COUNT_W-1:0]    count;
    logic                  last;
    logic                  done;
    err_code_t             err;
  } chunk_t;

  chunk_t             pending_chunks[$];
  byte_t              window_mem[WINDOW_BYTES];
  parse_stage_t       stage;
  logic [LIT_W-1:0]   literals_left;
  logic [LEN_W-1:0]   copy_len;
  logic [4:0]         offset_hi;
  logic [SIZE_W-1:0]  produced;
  logic [SIZE_W-1:0]  size_limit;

  // Store one output byte in the history and advance the count
  function automatic void append_output(byte_t value);
    window_mem[produced[HIST_AW-1:0]] = value;
    produced = produced + 1'b1;
  endfunction

  // Queue one predicted chunk; lanes beyond the count read as zero
  function automatic void expect_chunk(byte_t [OUT_LANES-1:0] lanes, int count,
                                       logic last, err_code_t err);
    chunk_t c;
    c = '0;
    for (int k = 0; k < count; k++) c.lanes[k] = lanes[k];
    c.count = COUNT_W'(count);
    c.last  = last;
    c.done  = (produced >= size_limit);
    c.err   = err;
    pending_chunks = {pending_chunks, c};
  endfunction

  // Parse one compressed byte and predict the chunks it releases
  function automatic void decode_lzf_byte(byte_t data, logic restart);
    logic [SIZE_W-1:0]     offset;
    logic [SIZE_W-1:0]     remaining;
    logic [SIZE_W-1:0]     src;
    byte_t [OUT_LANES-1:0] lanes;
    int                    fill;
    err_code_t             err;
    if (restart) begin
      stage         = EXPECT_CONTROL;
      literals_left = '0;
      copy_len      = '0;
      offset_hi     = '0;
      produced      = '0;
    end
    // drop everything once the stream is complete
    if (produced >= size_limit) return;
    case (stage)
      EXPECT_CONTROL: begin
        if (data < LIT_LIMIT) begin
          literals_left = LIT_W'(data[4:0]) + 1'b1;
          stage = EXPECT_LITERAL;
        end else begin
          offset_hi = data[4:0];
          if (data[7:5] == LEN_EXT) begin
            stage = EXPECT_LENGTH;
          end else begin
            copy_len = LEN_W'(data[7:5]) + LEN_BIAS;
            stage = EXPECT_OFFSET;
          end
        end
      end
      EXPECT_LITERAL: begin
        append_output(data);
        if (literals_left != 0) literals_left = literals_left - 1'b1;
        if (literals_left == 0) stage = EXPECT_CONTROL;
        lanes = '0;
        lanes[0] = data;
        expect_chunk(lanes, 1, 1'b1, ERR_NONE);
      end
      EXPECT_LENGTH: begin
        copy_len = LEN_EXT_BIAS + LEN_W'(data);
        stage = EXPECT_OFFSET;
      end
      default: begin
        stage = EXPECT_CONTROL;
        offset = SIZE_W'({offset_hi, data}) + 1'b1;
        // reject a reference before the first output byte
        if (offset > produced) begin
          lanes = '0;
          expect_chunk(lanes, 0, 1'b1, ERR_OFFSET);
          return;
        end
        remaining = SIZE_W'(copy_len);
        err = ERR_NONE;
        if (remaining > size_limit - produced) begin
          remaining = size_limit - produced;
          err = ERR_TRUNC;
        end
        // copy byte by byte so overlapping references repeat
        while (remaining != 0) begin
          lanes = '0;
          fill = 0;
          while (fill < CHUNK_BYTES && remaining != 0) begin
            src = produced - offset;
            lanes[fill] = window_mem[src[HIST_AW-1:0]];
            append_output(lanes[fill]);
            fill++;
            remaining = remaining - 1'b1;
          end
          expect_chunk(lanes, fill, remaining == 0, (remaining == 0) ? err : ERR_NONE);
        end
      end
    endcase
  endfunction

  function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // Compare one accepted chunk with the oldest prediction
  function automatic void check_chunk();
    chunk_t                want;
    byte_t [OUT_LANES-1:0] got_lanes;
    got_lanes = {out_mon.out_byte_7, out_mon.out_byte_6, out_mon.out_byte_5,
                 out_mon.out_byte_4, out_mon.out_byte_3, out_mon.out_byte_2,
                 out_mon.out_byte_1, out_mon.out_byte_0};
    if (pending_chunks.size() == 0) begin
      mismatches++;
      $display("%0t ns: chunk with none expected, expected nothing, got count %0h byte_0 %0h",
               $time, out_mon.byte_count, out_mon.out_byte_0);
      return;
    end
    want = pending_chunks.pop_front();
    for (int k = 0; k < OUT_LANES; k++)
      flag_field($sformatf("out_byte_%0d", k), want.lanes[k], got_lanes[k]);
    flag_field("byte_count", want.count, out_mon.byte_count);
    flag_field("run_last", want.last, out_mon.run_last);
    flag_field("stream_done", want.done, out_mon.stream_done);
    flag_field("error_code", want.err, out_mon.error_code);
  endfunction

  // Check first, then predict: a chunk never leaves on the edge its byte enters
  always @(posedge clk) begin
    if (!rst_n) begin
      stage         = EXPECT_CONTROL;
      literals_left = '0;
      copy_len      = '0;
      offset_hi     = '0;
      produced      = '0;
      size_limit    = '0;
      pending_chunks.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_chunk();
      if (in_mon.valid && in_mon.ready)
        decode_lzf_byte(in_mon.data_byte, in_mon.start_of_stream);
      if (cfg_we) size_limit = cfg_wdata;
    end
    chunks_awaited = pending_chunks.size();
  end

endmodule

// ===== test/lzf_stream_decompressor_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzf_stream_decompressor_tb
// Feeds LZF streams into the decompressor: a directed part for the corner
// cases, one stream deep enough to wrap the 8 KiB history, then random
// well-formed streams mixed with noise and bad references, under three
// sender/receiver idling mixes. The checker predicts and compares chunks.
// ---------------------------------------------------------------------------
module lzf_stream_decompressor_tb;
  import lzf_pkg::*;

  localparam int ITEM_TARGET   = 360;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RESET_CYCLES  = 5;
  localparam int DEEP_SIZE     = 12000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  lzf_in_if  in_chan();
  lzf_out_if out_chan();

  int mismatches;
  int chunks_awaited;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  // stream under construction
  byte_t       stream_bytes[$];
  int          gen_produced;
  logic [31:0] gen_size;
  int          live_items;

  lzf_stream_decompressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  lzf_output_checker chunk_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatches     (mismatches),
    .chunks_awaited (chunks_awaited)
  );

  always #5 clk = ~clk;

  // Stall the receiver at random
  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one compressed byte and hold it until accepted
  task automatic send_byte(input byte_t data, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.data_byte       <= data;
    in_chan.start_of_stream <= restart;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted chunk is out, then settle
  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    while (chunks_awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_output_size(input logic [SIZE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void queue_byte(byte_t value);
    stream_bytes = {stream_bytes, value};
    if (gen_produced < gen_size) live_items++;
  endfunction

  function automatic void add_literals(int count);
    queue_byte(byte_t'(count - 1));
    repeat (count) begin
      queue_byte(byte_t'($urandom));
      gen_produced++;
    end
  endfunction

  // Encode a back reference; short lengths fit in the control byte
  function automatic void add_match(int len, int offset);
    int ofs_code;
    ofs_code = offset - 1;
    if (len - int'(LEN_BIAS) < int'(LEN_EXT)) begin
      queue_byte(byte_t'(((len - int'(LEN_BIAS)) << 5) | (ofs_code >> 8)));
    end else begin
      queue_byte(byte_t'((int'(LEN_EXT) << 5) | (ofs_code >> 8)));
      queue_byte(byte_t'(len - int'(LEN_EXT_BIAS)));
    end
    queue_byte(byte_t'(ofs_code & 8'hFF));
    if (offset <= gen_produced) gen_produced += len;
  endfunction

  // Mostly literal runs and valid references, some bad references and noise
  function automatic void add_token();
    int pick;
    int reach;
    int len;
    int bad_top;
    pick  = $urandom_range(99);
    reach = (gen_produced < WINDOW_BYTES) ? gen_produced : WINDOW_BYTES;
    if (pick < 8) begin
      queue_byte(byte_t'($urandom));
    end else if (pick < 15 && gen_produced < WINDOW_BYTES) begin
      bad_top = (gen_produced + 40 > WINDOW_BYTES) ? WINDOW_BYTES : gen_produced + 40;
      add_match($urandom_range(3, 12), $urandom_range(gen_produced + 1, bad_top));
    end else if (pick < 55 || reach == 0) begin
      add_literals(($urandom_range(3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6));
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(3, 264) : $urandom_range(3, 18);
      add_match(len, ($urandom_range(1) == 0) ? $urandom_range(1, (reach < 4) ? reach : 4)
                                               : $urandom_range(1, reach));
    end
  endfunction

  function automatic void build_stream(logic [31:0] size, bit deep);
    int budget;
    int tokens;
    stream_bytes.delete();
    gen_produced = 0;
    gen_size     = size;
    if (deep) begin
      // fill past the window with long copies, then reach back its full depth
      add_literals(4);
      while (gen_produced < WINDOW_BYTES + 100)
        add_match(264, $urandom_range(1, (gen_produced < WINDOW_BYTES) ? gen_produced
                                                                       : WINDOW_BYTES));
      add_match(264, WINDOW_BYTES);
      repeat (5) add_match($urandom_range(3, 40), $urandom_range(WINDOW_BYTES - 64,
                                                                 WINDOW_BYTES));
      add_literals(32);
      return;
    end
    budget = $urandom_range(8, 30);
    tokens = 0;
    while (gen_produced < size && tokens < budget) begin
      add_token();
      tokens++;
    end
    // up to two more tokens, dropped if they land after the stream is complete
    repeat ($urandom_range(0, 2)) add_token();
  endfunction

  task automatic run_random_stream(input bit deep);
    logic [31:0] size;
    logic [31:0] later_size;
    int          split;
    if (deep) size = DEEP_SIZE;
    else if ($urandom_range(9) == 0) size = 32'hFFFF_FFFF;
    else size = $urandom_range(1, 180);
    wait_for_results();
    load_output_size(size);
    build_stream(size, deep);
    // sometimes change the size mid-stream, lowering or raising it
    split = (!deep && $urandom_range(3) == 0) ? $urandom_range(1, stream_bytes.size() - 1)
                                              : -1;
    if ($urandom_range(1) == 0) later_size = $urandom_range(0, 24);
    else if (size > 32'hFFFF_0000) later_size = size;
    else later_size = size + $urandom_range(1, 64);
    foreach (stream_bytes[i]) begin
      if (i == split) begin
        wait_for_results();
        load_output_size(later_size);
      end else if ($urandom_range(49) == 0) begin
        wait_for_results();
      end
      send_byte(stream_bytes[i], i == 0);
    end
  endtask

  task automatic run_directed();
    // zero size: every byte dropped
    load_output_size('0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_for_results();
    load_output_size(32'd40);
    // literal run of three with extreme bytes
    send_byte(8'h02, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    // reference before the start of output
    send_byte(8'h20, 1'b0);
    send_byte(8'h03, 1'b0);
    // overlapping copy at distance one
    send_byte(8'h20, 1'b0);
    send_byte(8'h00, 1'b0);
    // extended length of 14 at distance three
    send_byte(8'hE0, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b0);
    // longest copy, cut at the stream size
    send_byte(8'hE0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // dropped after completion
    send_byte(8'h1F, 1'b0);
    // lower the size below the count, then raise it to the maximum
    wait_for_results();
    load_output_size(32'd100);
    send_byte(8'h01, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    wait_for_results();
    load_output_size(32'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h33, 1'b0);
    wait_for_results();
    load_output_size(32'hFFFF_FFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h44, 1'b0);
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    in_chan.valid           = 1'b0;
    in_chan.data_byte       = '0;
    in_chan.start_of_stream = 1'b0;
    out_chan.ready          = 1'b0;
    send_idle_pct           = 28;
    recv_idle_pct           = 47;
    live_items              = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // three idling mixes: sender light, sender heavy, no idling
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 28 : (p == 1) ? 47 : 0;
      recv_idle_pct = (p == 0) ? 47 : (p == 1) ? 28 : 0;
      if (p == 0) begin
        run_directed();
        run_random_stream(1'b1);
      end
      while (live_items < ITEM_TARGET * (p + 1) / 3) run_random_stream(1'b0);
    end

    wait_for_results();
    if (mismatches == 0 && chunks_awaited == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
